// ===== hdl/tea_pkg.sv =====
// tea_pkg: types, constants and key selection for the TEA block cipher.
// Used by tea_cell and tea_block_cipher; depends on nothing.
package tea_pkg;

   localparam int ROUNDS = 32;
   localparam int CELLS  = 2 * ROUNDS;
   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] DELTA   = 32'h9e3779b9;
   localparam logic [WORD_W-1:0] SUM_DEC = WORD_W'(64'(DELTA) * ROUNDS);
   localparam logic [WORD_W-1:0] SUM_END = WORD_W'(64'(DELTA) * (ROUNDS + 1));

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [1:0] KEY_IDX_0 = 2'd0;
   localparam logic [1:0] KEY_IDX_1 = 2'd1;
   localparam logic [1:0] KEY_IDX_2 = 2'd2;
   localparam logic [1:0] KEY_IDX_3 = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] half_left;
      logic [WORD_W-1:0] half_right;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_left;
      logic [WORD_W-1:0] out_right;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] k0;
      logic [WORD_W-1:0] k1;
      logic [WORD_W-1:0] k2;
      logic [WORD_W-1:0] k3;
   } key_type;

   // x is the half updated by the next cell, y the half mixed into it
   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic              phase;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] sum;
   } cell_type;

endpackage

// ===== hdl/tea_cell.sv =====
// tea_cell: one half round of TEA, registered; swaps the halves on the way out.
// Depends on tea_pkg.
module tea_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  tea_pkg::key_type  key,
   input  tea_pkg::cell_type cell_i,
   output tea_pkg::cell_type cell_o
);
   import tea_pkg::*;

   cell_type          cell_ff;
   cell_type          cell_in;
   logic [WORD_W-1:0] ka;
   logic [WORD_W-1:0] kb;
   logic [WORD_W-1:0] mix;

   always_comb begin
      if (cell_i.phase ^ cell_i.cmd) begin
         ka = key.k2;
         kb = key.k3;
      end else begin
         ka = key.k0;
         kb = key.k1;
      end
      mix = ((cell_i.y << 4) + ka) ^ (cell_i.y + cell_i.sum) ^ ((cell_i.y >> 5) + kb);
      cell_in       = cell_i;
      cell_in.phase = ~cell_i.phase;
      cell_in.x     = cell_i.y;
      cell_in.y     = (cell_i.cmd == CMD_DECRYPT) ? cell_i.x - mix : cell_i.x + mix;
      if (cell_i.phase) begin
         cell_in.sum = (cell_i.cmd == CMD_DECRYPT) ? cell_i.sum - DELTA
                                                   : cell_i.sum + DELTA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

// ===== hdl/tea_block_cipher.sv =====
// tea_block_cipher: TEA encrypt/decrypt engine, one half-round cell per stage.
// Depends on tea_pkg and tea_cell.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_data  (cmd, half_left, half_right)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data  (out_left, out_right)
//   csr     | in        | csr_we              | csr_index, csr_wdata (key words 0..3)
//
// One request per cycle while the response side is not stalled; each half round cell registers its result.
// Synchronous reset clears the stage valid bits and the key words.
// A stalled response freezes the whole chain and stalls the request side.
module tea_block_cipher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tea_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tea_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [tea_pkg::WORD_W-1:0]    csr_wdata
);
   import tea_pkg::*;

   key_type  key_ff;
   key_type  key_in;
   cell_type head;
   cell_type chain [CELLS+1];
   cell_type last;
   logic     advance;

   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         case (csr_index)
            KEY_IDX_0: key_in.k0 = csr_wdata;
            KEY_IDX_1: key_in.k1 = csr_wdata;
            KEY_IDX_2: key_in.k2 = csr_wdata;
            KEY_IDX_3: key_in.k3 = csr_wdata;
            default:   key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign advance = ~(last.valid & rsp_stall);
   assign req_stall = ~advance;

   // decrypt enters with the halves swapped so the right half is updated first
   always_comb begin
      head.valid = req_valid;
      head.cmd   = req_data.cmd;
      head.phase = 1'b0;
      if (req_data.cmd == CMD_DECRYPT) begin
         head.x   = req_data.half_right;
         head.y   = req_data.half_left;
         head.sum = SUM_DEC;
      end else begin
         head.x   = req_data.half_left;
         head.y   = req_data.half_right;
         head.sum = DELTA;
      end
   end

   assign chain[0] = head;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      tea_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .key     (key_ff),
         .cell_i  (chain[i]),
         .cell_o  (chain[i+1])
      );
   end

   assign last      = chain[CELLS];
   assign rsp_valid = last.valid;

   always_comb begin
      if (last.cmd == CMD_DECRYPT) begin
         rsp_data.out_left  = last.y;
         rsp_data.out_right = last.x;
      end else begin
         rsp_data.out_left  = last.x;
         rsp_data.out_right = last.y;
      end
   end

`ifndef NO_ASSERTIONS
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while response is stalled");

   a_phase_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !last.phase)
      else $error("odd number of half rounds at the chain end");

   a_sum_enc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last.cmd == CMD_ENCRYPT |-> last.sum == SUM_END)
      else $error("encrypt round sum wrong at the chain end");

   a_sum_dec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last.cmd == CMD_DECRYPT |-> last.sum == '0)
      else $error("decrypt round sum wrong at the chain end");
`endif

endmodule
